/* design/tts_pkg.sv */
// Shared types and constants for the tone table sequencer.
// Depends on nothing; every other design file refers to it.
package tts_pkg;

    localparam int unsigned OPCODE_W       = 3;
    localparam int unsigned ADDR_W         = 6;
    localparam int unsigned FREQ_W         = 16;
    localparam int unsigned DUR_W          = 16;
    localparam int unsigned TIMER_W        = 16;
    localparam int unsigned TONE_CLK_W     = 24;
    localparam int unsigned TICKS_W        = 16;
    localparam int unsigned CFG_IDX_W      = 1;
    localparam int unsigned CFG_DATA_W     = 24;

    localparam int unsigned DEF_TABLE_ENTRIES = 64;
    localparam int unsigned DEF_END_CODE      = 65535;
    localparam int unsigned DEF_REPEAT_CODE   = 65534;

    localparam logic [TONE_CLK_W-1:0] TONE_CLK_RESET = 24'd1000000;
    localparam logic [TICKS_W-1:0]    TICKS_RESET    = 16'd10;
    localparam logic [TIMER_W-1:0]    SILENT_RELOAD  = 16'hFFFF;

    // One quotient bit is produced per divider step.
    localparam int unsigned DIV_STEPS = TONE_CLK_W;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

    typedef enum logic [OPCODE_W-1:0] {
        OP_WRITE     = 3'd0,
        OP_START_FWD = 3'd1,
        OP_START_REV = 3'd2,
        OP_EXPIRE    = 3'd3,
        OP_MUTE      = 3'd4
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TONE_CLOCK = 1'd0,
        CFG_TICKS      = 1'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        RES_NONE   = 2'd0,
        RES_STOP   = 2'd1,
        RES_UPDATE = 2'd2
    } result_kind_t;

    typedef struct packed {
        logic         wr_entry;
        logic         start_fwd;
        logic         scan_init;
        logic         scan_next;
        logic         scan_found;
        logic         set_pos;
        logic         mem_rd;
        logic         jump_start;
        logic         jump_end;
        logic         halt;
        logic         note_start;
        logic         div_step;
        logic         emit;
        result_kind_t kind;
    } tts_cmd_t;

    typedef struct packed {
        logic active;
        logic going_forward;
        logic melody_empty;
        logic is_repeat;
        logic is_marker;
        logic div_done;
        logic out_free;
    } tts_sts_t;

endpackage

/* design/tts_channels.sv */
// Handshake channel interfaces: command input, result output, configuration.
// Depends on tts_pkg for field widths.
interface tts_in_if;
    logic                             valid;
    logic                             ready;
    logic [tts_pkg::OPCODE_W-1:0]     opcode;
    logic [tts_pkg::ADDR_W-1:0]       entry_addr;
    logic [tts_pkg::FREQ_W-1:0]       tone_freq;
    logic [tts_pkg::DUR_W-1:0]        tone_dur;

    modport source (output valid, output opcode, output entry_addr, output tone_freq,
                    output tone_dur, input ready);
    modport sink   (input valid, input opcode, input entry_addr, input tone_freq,
                    input tone_dur, output ready);
endinterface

interface tts_out_if;
    logic                             valid;
    logic                             ready;
    logic                             update;
    logic                             stop;
    logic [tts_pkg::TIMER_W-1:0]      tone_reload;
    logic [tts_pkg::TIMER_W-1:0]      tone_compare;
    logic [tts_pkg::TIMER_W-1:0]      note_compare;
    logic                             playing;

    modport source (output valid, output update, output stop, output tone_reload,
                    output tone_compare, output note_compare, output playing,
                    input ready);
    modport sink   (input valid, input update, input stop, input tone_reload,
                    input tone_compare, input note_compare, input playing,
                    output ready);
endinterface

interface tts_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [tts_pkg::CFG_IDX_W-1:0]    index;
    logic [tts_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/tts_datapath.sv */
// Datapath: note table memory, playback position registers, serial divider,
// duration multiplier and the result register. Depends on tts_pkg and tts_channels.
module tts_datapath #(
    parameter int unsigned TABLE_ENTRIES = tts_pkg::DEF_TABLE_ENTRIES,
    parameter int unsigned END_CODE      = tts_pkg::DEF_END_CODE,
    parameter int unsigned REPEAT_CODE   = tts_pkg::DEF_REPEAT_CODE
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [tts_pkg::ADDR_W-1:0]    entry_addr,
    input  logic [tts_pkg::FREQ_W-1:0]    tone_freq,
    input  logic [tts_pkg::DUR_W-1:0]     tone_dur,
    input  tts_pkg::tts_cmd_t             cmd,
    output tts_pkg::tts_sts_t             sts,
    tts_out_if.source                     out_ch,
    tts_cfg_if.sink                       cfg_ch
);
    import tts_pkg::*;

    localparam int unsigned IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int unsigned POS_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int unsigned WORD_W = FREQ_W + DUR_W;
    localparam logic [POS_W-1:0]  POS_LIMIT = POS_W'(TABLE_ENTRIES);
    localparam logic [FREQ_W-1:0] END_F     = FREQ_W'(END_CODE);
    localparam logic [FREQ_W-1:0] REPEAT_F  = FREQ_W'(REPEAT_CODE);

    logic [WORD_W-1:0] mem [TABLE_ENTRIES];

    logic [TONE_CLK_W-1:0] tone_clk_reg;
    logic [TICKS_W-1:0]    ticks_reg;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [POS_W-1:0]      note_pos_reg, note_pos_next;
    logic [POS_W-1:0]      melody_len_reg, melody_len_next;
    logic                  fwd_reg, fwd_next;
    logic                  active_reg, active_next;
    logic [WORD_W-1:0]     rd_data_reg;
    logic                  rd_oob_reg;
    logic [TONE_CLK_W-1:0] quo_reg;
    logic [FREQ_W-1:0]     rem_reg;
    logic [FREQ_W-1:0]     divisor_reg;
    logic [DIV_CNT_W-1:0]  div_cnt_reg;
    logic                  silent_reg;
    logic [TIMER_W-1:0]    prod_reg;
    logic                  out_valid_reg;
    logic                  res_update_reg, res_stop_reg, res_playing_reg;
    logic [TIMER_W-1:0]    res_reload_reg, res_compare_reg, res_note_reg;

    logic [FREQ_W-1:0]     rd_freq, eff_freq;
    logic [DUR_W-1:0]      rd_dur;
    logic                  addr_ok;
    logic [FREQ_W:0]       trial;
    logic                  trial_ge;
    logic [TICKS_W+DUR_W-1:0] prod_full;
    logic [TIMER_W:0]      reload_wide;

    assign rd_freq  = rd_data_reg[WORD_W-1:DUR_W];
    assign rd_dur   = rd_data_reg[DUR_W-1:0];
    assign eff_freq = rd_oob_reg ? END_F : rd_freq;
    assign addr_ok  = 32'(entry_addr) < 32'(TABLE_ENTRIES);

    assign sts.active        = active_reg;
    assign sts.going_forward = fwd_reg;
    assign sts.melody_empty  = (melody_len_reg == '0);
    assign sts.is_repeat     = (eff_freq == REPEAT_F);
    assign sts.is_marker     = (eff_freq == REPEAT_F) || (eff_freq == END_F);
    assign sts.div_done      = (div_cnt_reg == '0);
    assign sts.out_free      = !out_valid_reg || out_ch.ready;

    assign cfg_ch.ready = 1'b1;

    // Note table: one write port for table loads, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_entry && addr_ok)
        begin
            mem[IDX_W'(entry_addr)] <= {tone_freq, tone_dur};
        end
        if (cmd.mem_rd)
        begin
            rd_data_reg <= mem[pos_reg[IDX_W-1:0]];
        end
    end

    always_comb
    begin
        pos_next        = pos_reg;
        note_pos_next   = note_pos_reg;
        melody_len_next = melody_len_reg;
        fwd_next        = fwd_reg;
        active_next     = active_reg;
        if (cmd.start_fwd)
        begin
            fwd_next      = 1'b1;
            note_pos_next = '0;
            active_next   = 1'b1;
        end
        if (cmd.scan_init)
        begin
            pos_next = '0;
        end
        if (cmd.scan_next)
        begin
            pos_next = pos_reg + POS_W'(1);
        end
        if (cmd.scan_found)
        begin
            melody_len_next = pos_reg;
            note_pos_next   = pos_reg;
            fwd_next        = 1'b0;
            active_next     = 1'b1;
        end
        if (cmd.set_pos)
        begin
            if (fwd_reg)
            begin
                pos_next = note_pos_reg;
            end
            else if (note_pos_reg == '0)
            begin
                pos_next = melody_len_reg;
            end
            else
            begin
                pos_next = note_pos_reg - POS_W'(1);
            end
        end
        if (cmd.jump_start)
        begin
            pos_next = '0;
        end
        if (cmd.jump_end)
        begin
            pos_next = melody_len_reg - POS_W'(1);
        end
        if (cmd.note_start)
        begin
            note_pos_next = fwd_reg ? pos_reg + POS_W'(1) : pos_reg;
        end
        if (cmd.halt)
        begin
            active_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tone_clk_reg   <= TONE_CLK_RESET;
            ticks_reg      <= TICKS_RESET;
            pos_reg        <= '0;
            note_pos_reg   <= '0;
            melody_len_reg <= '0;
            fwd_reg        <= 1'b1;
            active_reg     <= 1'b0;
            rd_oob_reg     <= 1'b0;
            div_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_reg_t'(cfg_ch.index))
                    CFG_TONE_CLOCK: tone_clk_reg <= cfg_ch.data;
                    CFG_TICKS:      ticks_reg    <= cfg_ch.data[TICKS_W-1:0];
                    default:        ;
                endcase
            end
            pos_reg        <= pos_next;
            note_pos_reg   <= note_pos_next;
            melody_len_reg <= melody_len_next;
            fwd_reg        <= fwd_next;
            active_reg     <= active_next;
            if (cmd.mem_rd)
            begin
                rd_oob_reg <= (pos_reg >= POS_LIMIT);
            end
            if (cmd.note_start)
            begin
                div_cnt_reg <= DIV_CNT_W'(DIV_STEPS);
            end
            else if (cmd.div_step && div_cnt_reg != '0)
            begin
                div_cnt_reg <= div_cnt_reg - DIV_CNT_W'(1);
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Restoring divider: one quotient bit per step, dividend shifted out of quo_reg.
    assign trial    = {rem_reg, quo_reg[TONE_CLK_W-1]};
    assign trial_ge = (trial >= {1'b0, divisor_reg});
    assign prod_full = ticks_reg * rd_dur;

    // The low 17 bits of (quotient - 1) give both the reload and half of it.
    assign reload_wide = quo_reg[TIMER_W:0] - (TIMER_W+1)'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.note_start)
        begin
            quo_reg     <= tone_clk_reg;
            rem_reg     <= '0;
            divisor_reg <= eff_freq;
            silent_reg  <= (eff_freq == '0);
            prod_reg    <= prod_full[TIMER_W-1:0];
        end
        else if (cmd.div_step && div_cnt_reg != '0)
        begin
            quo_reg <= {quo_reg[TONE_CLK_W-2:0], trial_ge};
            rem_reg <= trial_ge ? FREQ_W'(trial - {1'b0, divisor_reg}) : trial[FREQ_W-1:0];
        end
        if (cmd.emit)
        begin
            res_playing_reg <= active_reg;
            res_update_reg  <= (cmd.kind == RES_UPDATE);
            res_stop_reg    <= (cmd.kind == RES_STOP);
            if (cmd.kind == RES_UPDATE)
            begin
                res_reload_reg  <= silent_reg ? SILENT_RELOAD : reload_wide[TIMER_W-1:0];
                res_compare_reg <= silent_reg ? '0 : reload_wide[TIMER_W:1];
                res_note_reg    <= prod_reg - TIMER_W'(1);
            end
            else
            begin
                res_reload_reg  <= '0;
                res_compare_reg <= '0;
                res_note_reg    <= '0;
            end
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.update       = res_update_reg;
    assign out_ch.stop         = res_stop_reg;
    assign out_ch.tone_reload  = res_reload_reg;
    assign out_ch.tone_compare = res_compare_reg;
    assign out_ch.note_compare = res_note_reg;
    assign out_ch.playing      = res_playing_reg;

`ifndef NO_ASSERTIONS
    a_emit_into_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ch.ready))
        else $error("result loaded while the previous one is still held");
    a_note_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        note_pos_reg <= POS_LIMIT && melody_len_reg <= POS_LIMIT)
        else $error("playback position beyond the table");
    a_stop_clears_active: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.kind == RES_STOP) |-> !active_reg)
        else $error("stop result while playback still active");
    a_update_when_active: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.kind == RES_UPDATE) |-> (active_reg && div_cnt_reg == '0))
        else $error("note result before the divider finished");
`endif

endmodule

/* design/tts_ctrl.sv */
// Controller state machine: decodes commands, sequences the terminator scan,
// table reads, the divider and the result transfer. Depends on tts_pkg.
module tts_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [tts_pkg::OPCODE_W-1:0]  in_opcode,
    output logic                          in_ready,
    output tts_pkg::tts_cmd_t             cmd,
    input  tts_pkg::tts_sts_t             sts
);
    import tts_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_SCAN_RD  = 10'b00_0000_0010,
        S_SCAN_CHK = 10'b00_0000_0100,
        S_ADV      = 10'b00_0000_1000,
        S_RD1      = 10'b00_0001_0000,
        S_CHK1     = 10'b00_0010_0000,
        S_RD2      = 10'b00_0100_0000,
        S_CHK2     = 10'b00_1000_0000,
        S_DIV      = 10'b01_0000_0000,
        S_EMIT     = 10'b10_0000_0000
    } state_t;

    state_t       state_reg, state_next;
    result_kind_t kind_reg, kind_next;
    logic         accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        cmd.kind   = kind_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (opcode_t'(in_opcode))
                        OP_WRITE:
                        begin
                            cmd.wr_entry = 1'b1;
                            kind_next    = RES_NONE;
                            state_next   = S_EMIT;
                        end
                        OP_START_FWD:
                        begin
                            cmd.start_fwd = 1'b1;
                            state_next    = S_ADV;
                        end
                        OP_START_REV:
                        begin
                            cmd.scan_init = 1'b1;
                            state_next    = S_SCAN_RD;
                        end
                        OP_EXPIRE:
                        begin
                            state_next = S_ADV;
                        end
                        OP_MUTE:
                        begin
                            cmd.halt   = 1'b1;
                            kind_next  = RES_STOP;
                            state_next = S_EMIT;
                        end
                        default:
                        begin
                            kind_next  = RES_NONE;
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end
            S_SCAN_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                // A position past the table reads as the end marker, so the scan ends.
                if (sts.is_marker)
                begin
                    cmd.scan_found = 1'b1;
                    state_next     = S_ADV;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                    state_next    = S_SCAN_RD;
                end
            end
            S_ADV:
            begin
                if (sts.active)
                begin
                    cmd.set_pos = 1'b1;
                    state_next  = S_RD1;
                end
                else
                begin
                    kind_next  = RES_NONE;
                    state_next = S_EMIT;
                end
            end
            S_RD1:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_CHK1;
            end
            S_CHK1:
            begin
                if (!sts.is_repeat)
                begin
                    state_next = S_CHK2;
                end
                else if (sts.going_forward)
                begin
                    cmd.jump_start = 1'b1;
                    state_next     = S_RD2;
                end
                else if (sts.melody_empty)
                begin
                    cmd.halt   = 1'b1;
                    kind_next  = RES_STOP;
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.jump_end = 1'b1;
                    state_next   = S_RD2;
                end
            end
            S_RD2:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_CHK2;
            end
            S_CHK2:
            begin
                if (sts.is_marker)
                begin
                    cmd.halt   = 1'b1;
                    kind_next  = RES_STOP;
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.note_start = 1'b1;
                    state_next     = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                begin
                    kind_next  = RES_UPDATE;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= RES_NONE;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("controller still idle after a command transfer");
    a_div_done_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && sts.div_done) |=> (state_reg == S_EMIT && kind_reg == RES_UPDATE))
        else $error("finished division did not lead to a note result");
    a_emit_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (state_reg == S_IDLE))
        else $error("controller did not return to idle after the result transfer");
`endif

endmodule

/* design/tone_table_sequencer_unit.sv */
// Tone table sequencer top level: ties the controller to the datapath.
// Write, mute and unused codes go straight to the result; an idle expiry passes the advance
// state; a stop at a marker or a note reads the table (again after a repeat jump); a note then
// runs the 24-step divider. Reverse start scans for the terminator, at most TABLE_ENTRIES+1 reads.
// Throughput: one command at a time; the next is taken once the result is in the output register.
// Reset (rst_n, asynchronous): idle, not playing, forward order; table contents undefined.
module tone_table_sequencer_unit #(
    parameter int unsigned TABLE_ENTRIES = tts_pkg::DEF_TABLE_ENTRIES,
    parameter int unsigned END_CODE      = tts_pkg::DEF_END_CODE,
    parameter int unsigned REPEAT_CODE   = tts_pkg::DEF_REPEAT_CODE
) (
    input  logic        clk,
    input  logic        rst_n,
    tts_in_if.sink      cmd,
    tts_out_if.source   rsp,
    tts_cfg_if.sink     cfg
);
    import tts_pkg::*;

    tts_cmd_t ctrl_cmd;
    tts_sts_t dp_sts;
    logic     in_ready;

    assign cmd.ready = in_ready;

    tts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_opcode (cmd.opcode),
        .in_ready  (in_ready),
        .cmd       (ctrl_cmd),
        .sts       (dp_sts)
    );

    tts_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .END_CODE      (END_CODE),
        .REPEAT_CODE   (REPEAT_CODE)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .entry_addr (cmd.entry_addr),
        .tone_freq  (cmd.tone_freq),
        .tone_dur   (cmd.tone_dur),
        .cmd        (ctrl_cmd),
        .sts        (dp_sts),
        .out_ch     (rsp),
        .cfg_ch     (cfg)
    );

endmodule
